// File: src/ntre_pkg.sv
`timescale 1ns / 1ps

package ntre_pkg;

  // Bytes taken into account per record; later bytes are ignored until tlast
  localparam int MAX_RECORD_BYTES = 256;
  localparam int BCNT_W           = $clog2(MAX_RECORD_BYTES + 1);

  localparam logic [2:0] TNF_MASK     = 3'h7;
  localparam logic [2:0] TNF_WELL_KN  = 3'h1;
  localparam int         SR_BIT       = 4;
  localparam int         IL_BIT       = 3;
  localparam logic [7:0] TYPE_TEXT    = 8'h54;  // 'T'
  localparam logic [7:0] MAX_TEXT_RST = 8'd63;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;

  typedef enum logic [3:0] {
    PH_HEADER,
    PH_TYPELEN,
    PH_PLEN,
    PH_IDLEN,
    PH_TYPE,
    PH_IDSKIP,
    PH_STATUS,
    PH_LANG,
    PH_TEXT,
    PH_DRAIN
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_NOT_WK   = 3'd2,
    ST_NOT_TEXT = 3'd3,
    ST_BAD_PLEN = 3'd4,
    ST_EMPTY    = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_valid;
    logic       done_res;
    status_t    status;
  } result_t;

endpackage

// File: src/ntre_parse.sv
`timescale 1ns / 1ps

module ntre_parse
  import ntre_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] data_byte,
  input  logic       last,
  input  logic [7:0] max_text_len,
  output logic       res_present,
  output result_t    res
);

  phase_t              phase, phase_next;
  logic                short_record, short_record_next;
  logic                id_present, id_present_next;
  logic [7:0]          type_length, type_length_next;
  logic [31:0]         payload_length, payload_length_next;
  logic [7:0]          id_length, id_length_next;
  logic [7:0]          skip_count, skip_count_next;
  logic [7:0]          text_remaining, text_remaining_next;
  logic [BCNT_W-1:0]   byte_count, byte_count_next;
  status_t             result_code, result_code_next;

  logic                is_text;
  logic [5:0]          lang;
  logic                plen_bad;
  logic [31:0]         avail;
  logic [7:0]          text_cap;
  logic [7:0]          skip_dec;

  assign lang     = data_byte[5:0];
  assign plen_bad = {1'b0, payload_length} < (33'(lang) + 33'd1);
  assign avail    = payload_length - 32'(lang) - 32'd1;
  assign text_cap = (avail < 32'(max_text_len)) ? avail[7:0] : max_text_len;
  assign skip_dec = skip_count - 8'd1;

  always_comb begin
    phase_next          = phase;
    short_record_next   = short_record;
    id_present_next     = id_present;
    type_length_next    = type_length;
    payload_length_next = payload_length;
    id_length_next      = id_length;
    skip_count_next     = skip_count;
    text_remaining_next = text_remaining;
    byte_count_next     = byte_count;
    result_code_next    = result_code;
    is_text             = 1'b0;

    if (byte_count < BCNT_W'(MAX_RECORD_BYTES)) begin
      byte_count_next = byte_count + BCNT_W'(1);
      unique case (phase)
        PH_HEADER: begin
          short_record_next = data_byte[SR_BIT];
          id_present_next   = data_byte[IL_BIT];
          if ((data_byte[2:0] & TNF_MASK) != TNF_WELL_KN) begin
            result_code_next = ST_NOT_WK;
            phase_next       = PH_DRAIN;
          end else begin
            phase_next = PH_TYPELEN;
          end
        end
        PH_TYPELEN: begin
          type_length_next = data_byte;
          phase_next       = PH_PLEN;
          skip_count_next  = short_record ? 8'd1 : 8'd4;
        end
        PH_PLEN: begin
          payload_length_next = {payload_length[23:0], data_byte};
          skip_count_next     = skip_dec;
          if (skip_dec == 8'd0) begin
            if (id_present) begin
              phase_next = PH_IDLEN;
            end else if (type_length != 8'd1) begin
              result_code_next = ST_NOT_TEXT;
              phase_next       = PH_DRAIN;
            end else begin
              phase_next = PH_TYPE;
            end
          end
        end
        PH_IDLEN: begin
          id_length_next = data_byte;
          if (type_length != 8'd1) begin
            result_code_next = ST_NOT_TEXT;
            phase_next       = PH_DRAIN;
          end else begin
            phase_next = PH_TYPE;
          end
        end
        PH_TYPE: begin
          if (data_byte != TYPE_TEXT) begin
            result_code_next = ST_NOT_TEXT;
            phase_next       = PH_DRAIN;
          end else if (id_length != 8'd0) begin
            skip_count_next = id_length;
            phase_next      = PH_IDSKIP;
          end else begin
            phase_next = PH_STATUS;
          end
        end
        PH_IDSKIP: begin
          skip_count_next = skip_dec;
          if (skip_dec == 8'd0) begin
            phase_next = PH_STATUS;
          end
        end
        PH_STATUS: begin
          if (plen_bad) begin
            result_code_next = ST_BAD_PLEN;
            phase_next       = PH_DRAIN;
          end else begin
            text_remaining_next = text_cap;
            result_code_next    = ST_EMPTY;
            if (lang != 6'd0) begin
              skip_count_next = 8'(lang);
              phase_next      = PH_LANG;
            end else begin
              phase_next = (text_cap == 8'd0) ? PH_DRAIN : PH_TEXT;
            end
          end
        end
        PH_LANG: begin
          skip_count_next = skip_dec;
          if (skip_dec == 8'd0) begin
            phase_next = (text_remaining == 8'd0) ? PH_DRAIN : PH_TEXT;
          end
        end
        PH_TEXT: begin
          text_remaining_next = text_remaining - 8'd1;
          result_code_next    = ST_OK;
          is_text             = 1'b1;
          if (text_remaining == 8'd1) begin
            phase_next = PH_DRAIN;
          end
        end
        PH_DRAIN: begin
          phase_next = PH_DRAIN;
        end
        default: begin
          phase_next = PH_DRAIN;
        end
      endcase
    end

    res_present    = is_text || last;
    res.text_byte  = is_text ? data_byte : 8'd0;
    res.text_valid = is_text;
    res.done_res   = last;
    if (!last) begin
      res.status = ST_OK;
    end else if (byte_count_next < BCNT_W'(3)) begin
      res.status = ST_SHORT;
    end else begin
      res.status = result_code_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (take && last)) begin
      phase          <= PH_HEADER;
      short_record   <= 1'b0;
      id_present     <= 1'b0;
      type_length    <= 8'd0;
      payload_length <= 32'd0;
      id_length      <= 8'd0;
      skip_count     <= 8'd0;
      text_remaining <= 8'd0;
      byte_count     <= '0;
      result_code    <= ST_SHORT;
    end else if (take) begin
      phase          <= phase_next;
      short_record   <= short_record_next;
      id_present     <= id_present_next;
      type_length    <= type_length_next;
      payload_length <= payload_length_next;
      id_length      <= id_length_next;
      skip_count     <= skip_count_next;
      text_remaining <= text_remaining_next;
      byte_count     <= byte_count_next;
      result_code    <= result_code_next;
    end
  end

endmodule

// File: src/ndef_text_record_extractor_unit.sv
`timescale 1ns / 1ps

// NDEF text record extractor.
// Feed one record byte per item on the s_ channel, tlast on its final byte.
// The block checks the record header (TNF well known, type 'T'), skips the
// ID and language code, and passes the text bytes out on the m_ channel,
// at most max_text_len of them per record. The item for the final input
// byte carries tlast and a status code (ok, too short, not well known, not
// text, bad payload length, empty text). Bytes that yield no text and are
// not final produce no output item.
// cfg_valid/cfg_data write max_text_len (reset value 63); write it only
// while no record is in flight. cfg_ready is always high.
// Throughput: one byte per cycle while the output is not stalled.
// An accepted item sits in the input register and is parsed from there
// when the parser advances; its result then enters the output register
// and raises m_tvalid, and the item leaves when m_tready is high.
// A stalled m_tready holds the output register; the input register keeps
// accepting while the held byte yields no result, else s_tready drops.
// rst (synchronous) empties both registers and returns the parser to the
// header phase with max_text_len back at 63.
module ndef_text_record_extractor_unit
  import ntre_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // tdata: [7:0] data_byte
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   s_tlast,
  // tdata: [7:0] text_byte, [10:8] status, [15:11] zero
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // tuser: [0] text_valid
  output logic                   m_tuser,
  output logic                   m_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [7:0]             cfg_data
);

  logic [7:0] max_text_len;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // output register
  result_t    out_res;

  logic       res_present;
  result_t    res;
  logic       advance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_text_len <= MAX_TEXT_RST;
    end else if (cfg_valid) begin
      max_text_len <= cfg_data;
    end
  end

  // Advance the held byte unless it makes a result and the output slot is
  // full and stalled.
  assign advance  = in_valid && (!res_present || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata[7:0];
      in_last <= s_tlast;
    end
  end

  ntre_parse u_parse (
    .clk          (clk),
    .rst          (rst),
    .take         (advance),
    .data_byte    (in_byte),
    .last         (in_last),
    .max_text_len (max_text_len),
    .res_present  (res_present),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && res_present) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_present) begin
      out_res <= res;
    end
  end

  assign m_tdata = {5'd0, out_res.status, out_res.text_byte};
  assign m_tuser = out_res.text_valid;
  assign m_tlast = out_res.done_res;

endmodule

// File: src/ntre_checker.sv
`timescale 1ns / 1ps

module ntre_checker
  import ntre_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // hold a stalled output item
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("output item changed while stalled");

  // an item without text must be the final one, with a zero byte
  a_no_text_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast && m_tdata[7:0] == 8'd0)
    else $error("empty item that is not final");

  // a text byte always reports ok and keeps the padding clear
  a_text_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[10:8] == ST_OK && m_tdata[15:11] == 5'd0)
    else $error("text item with nonzero status or padding");

  // final status is one of the defined codes
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[10:8] == ST_OK || m_tdata[10:8] == ST_SHORT
      || m_tdata[10:8] == ST_NOT_WK || m_tdata[10:8] == ST_NOT_TEXT
      || m_tdata[10:8] == ST_BAD_PLEN || m_tdata[10:8] == ST_EMPTY)
    else $error("undefined status code");

endmodule

bind ndef_text_record_extractor_unit ntre_checker u_ntre_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
